// ===== rtl/core/slse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slse_pkg
// Shared types, register offsets and read-sequence tables for the sound
// length, sweep and envelope unit.
// ----------------------------------------------------------------------------
package slse_pkg;

  localparam int AW    = 5;   // register offset width
  localparam int CAP_N = 6;   // most register reads one item needs
  localparam int WB_N  = 3;   // most register writes one item needs

  localparam logic [2:0] FN_WRITE  = 3'd0;
  localparam logic [2:0] FN_READ   = 3'd1;
  localparam logic [2:0] FN_TICK   = 3'd2;
  localparam logic [2:0] FN_RELOAD = 3'd3;
  localparam logic [2:0] FN_TRIG   = 3'd4;

  localparam logic [1:0] CH_SQ1   = 2'd0;
  localparam logic [1:0] CH_SQ2   = 2'd1;
  localparam logic [1:0] CH_WAVE  = 2'd2;
  localparam logic [1:0] CH_NOISE = 2'd3;

  localparam logic [AW-1:0] R_NR10 = 5'd0;
  localparam logic [AW-1:0] R_NR11 = 5'd1;
  localparam logic [AW-1:0] R_NR12 = 5'd2;
  localparam logic [AW-1:0] R_NR13 = 5'd3;
  localparam logic [AW-1:0] R_NR14 = 5'd4;
  localparam logic [AW-1:0] R_NR21 = 5'd6;
  localparam logic [AW-1:0] R_NR22 = 5'd7;
  localparam logic [AW-1:0] R_NR24 = 5'd9;
  localparam logic [AW-1:0] R_NR31 = 5'd11;
  localparam logic [AW-1:0] R_NR34 = 5'd14;
  localparam logic [AW-1:0] R_NR41 = 5'd16;
  localparam logic [AW-1:0] R_NR42 = 5'd17;
  localparam logic [AW-1:0] R_NR44 = 5'd19;
  localparam logic [AW-1:0] R_NR52 = 5'd22;

  localparam int          LEN_EN_BIT  = 6;
  localparam logic [10:0] FREQ_MAX    = 11'd2047;
  localparam logic [7:0]  ON_MASK     = 8'hF8;
  localparam logic [2:0]  PH_ENV      = 3'd4;

  typedef struct packed {
    logic [2:0]    func;
    logic [AW-1:0] idx;
    logic [7:0]    wdata;
    logic [1:0]    ch;
  } item_t;

  typedef struct packed {
    logic [WB_N-1:0]           en;
    logic [WB_N-1:0][AW-1:0]   addr;
    logic [WB_N-1:0][7:0]      data;
  } wb_t;

  typedef logic [CAP_N-1:0][7:0] cap_t;

  function automatic logic [AW-1:0] len_reg(input logic [1:0] ch);
    logic [AW-1:0] a;
    case (ch)
      CH_SQ1:  a = R_NR11;
      CH_SQ2:  a = R_NR21;
      CH_WAVE: a = R_NR31;
      default: a = R_NR41;
    endcase
    return a;
  endfunction

  function automatic logic [AW-1:0] vol_reg(input logic [1:0] ch);
    logic [AW-1:0] a;
    case (ch)
      CH_SQ1:  a = R_NR12;
      CH_SQ2:  a = R_NR22;
      default: a = R_NR42;
    endcase
    return a;
  endfunction

  // Register offset read at a given step of an item's read sequence.
  function automatic logic [AW-1:0] rd_addr(input item_t it, input logic ph_env,
                                            input logic [2:0] step);
    logic [AW-1:0] a;
    a = R_NR10;
    case (it.func)
      FN_READ:   a = it.idx;
      FN_TICK: begin
        if (ph_env) begin
          case (step)
            3'd0:    a = R_NR12;
            3'd1:    a = R_NR22;
            default: a = R_NR42;
          endcase
        end else begin
          case (step)
            3'd0:    a = R_NR14;
            3'd1:    a = R_NR24;
            3'd2:    a = R_NR34;
            3'd3:    a = R_NR44;
            3'd4:    a = R_NR52;
            default: a = R_NR10;
          endcase
        end
      end
      FN_RELOAD: a = len_reg(it.ch);
      FN_TRIG: begin
        case (step)
          3'd0:    a = len_reg(it.ch);
          3'd1:    a = vol_reg(it.ch);
          default: a = R_NR52;
        endcase
      end
      default:   a = R_NR10;
    endcase
    return a;
  endfunction

  function automatic logic [2:0] rd_count(input item_t it, input logic ph_env);
    logic [2:0] n;
    case (it.func)
      FN_READ:   n = 3'd1;
      FN_TICK:   n = ph_env ? 3'd3 : 3'd6;
      FN_RELOAD: n = 3'd1;
      FN_TRIG:   n = 3'd3;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [6:0] short_len(input logic [7:0] r);
    return 7'd64 - {1'b0, r[5:0]};
  endfunction

  function automatic logic [8:0] wave_len(input logic [7:0] r);
    return 9'd256 - {1'b0, r};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/slse_regmem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slse_regmem
// Sound register byte store: one write port, one registered read port.
// Entries never written read as zero.
// ----------------------------------------------------------------------------
module slse_regmem #(
  parameter int DEPTH = 23
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    we,
  input  wire logic [slse_pkg::AW-1:0] waddr,
  input  wire logic [7:0]              wdata,
  input  wire logic [slse_pkg::AW-1:0] raddr,
  output logic      [7:0]              rdata
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [slse_pkg::AW:0] DEPTH_W = (slse_pkg::AW + 1)'(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       rdata_r;
  logic             w_ok;
  logic             r_ok;

  assign w_ok  = ({1'b0, waddr} < DEPTH_W);
  assign r_ok  = ({1'b0, raddr} < DEPTH_W);
  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we && w_ok) begin
      mem[waddr[IW-1:0]] <= wdata;
    end
    if (r_ok && vld_r[raddr[IW-1:0]]) begin
      rdata_r <= mem[raddr[IW-1:0]];
    end else begin
      rdata_r <= 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we && w_ok) begin
      vld_r[waddr[IW-1:0]] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/slse_chan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slse_chan
// Channel state: length counters, envelope volumes, sweep count, frame phase.
// Works out one item from the fetched register bytes and produces the
// register write-back list.
// ----------------------------------------------------------------------------
module slse_chan (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 calc_en,
  input  wire slse_pkg::item_t      item,
  input  wire slse_pkg::cap_t       cap,
  input  wire logic [10:0]          freq,
  output slse_pkg::wb_t             wb,
  output logic [7:0]                rd_data,
  output logic [2:0][3:0]           vol,
  output logic                      ph_env
);

  logic [2:0][6:0] len_r, len_nxt;
  logic [8:0]      wlen_r, wlen_nxt;
  logic [2:0]      swc_r, swc_nxt;
  logic [2:0][3:0] vol_r, vol_nxt;
  // step counter kept as residues mod 2..7; 840 is a multiple of each
  logic [7:2][2:0] res_r, res_nxt;
  logic [2:0]      phase_r, phase_nxt;
  slse_pkg::wb_t   wb_r, wb_nxt;
  logic [7:0]      rd_r, rd_nxt;

  assign wb      = wb_r;
  assign rd_data = rd_r;
  assign vol     = vol_r;
  assign ph_env  = (phase_r == slse_pkg::PH_ENV);

  always_comb begin
    logic [3:0]  on;
    logic [7:0]  hit;
    logic [7:0]  nr10;
    logic [10:0] d;
    logic [11:0] sum;
    logic [10:0] f;
    logic [1:0]  slot;
    logic [7:0]  ectl;
    int          ci;
    int          ob;

    len_nxt   = len_r;
    wlen_nxt  = wlen_r;
    swc_nxt   = swc_r;
    vol_nxt   = vol_r;
    res_nxt   = res_r;
    phase_nxt = phase_r;
    wb_nxt    = '0;
    rd_nxt    = 8'd0;
    on        = cap[4][3:0];
    nr10      = cap[5];
    d         = freq >> nr10[2:0];
    sum       = nr10[3] ? ({1'b0, freq} - {1'b0, d}) : ({1'b0, freq} + {1'b0, d});
    f         = (sum > {1'b0, slse_pkg::FREQ_MAX}) ? slse_pkg::FREQ_MAX : sum[10:0];
    slot      = (item.ch == slse_pkg::CH_NOISE) ? 2'd2 : item.ch;
    ectl      = 8'd0;
    ci        = 0;
    ob        = 0;
    hit       = 8'b0000_0010;
    for (int k = 2; k < 8; k++) begin
      hit[k] = (res_r[k] == 3'd0);
    end

    case (item.func)
      slse_pkg::FN_WRITE: begin
        wb_nxt.en[0]   = 1'b1;
        wb_nxt.addr[0] = item.idx;
        wb_nxt.data[0] = item.wdata;
      end
      slse_pkg::FN_READ: begin
        rd_nxt = cap[0];
      end
      slse_pkg::FN_TICK: begin
        if (phase_r == slse_pkg::PH_ENV) begin
          for (int k = 0; k < 3; k++) begin
            ectl = cap[k];
            if (hit[ectl[2:0]]) begin
              if (ectl[3]) begin
                if (vol_r[k] != 4'hF) vol_nxt[k] = vol_r[k] + 4'd1;
              end else begin
                if (vol_r[k] != 4'h0) vol_nxt[k] = vol_r[k] - 4'd1;
              end
            end
          end
          for (int k = 2; k < 8; k++) begin
            res_nxt[k] = (res_r[k] == 3'(k - 1)) ? 3'd0 : res_r[k] + 3'd1;
          end
          phase_nxt = 3'd0;
        end else begin
          for (int k = 0; k < 3; k++) begin
            ci = (k == 2) ? 3 : k;
            ob = (k == 2) ? 3 : k;
            if (cap[ci][slse_pkg::LEN_EN_BIT] && len_r[k] != 7'd0) begin
              len_nxt[k] = len_r[k] - 7'd1;
              if (len_r[k] == 7'd1) on[ob] = 1'b0;
            end
          end
          if (cap[2][slse_pkg::LEN_EN_BIT] && wlen_r != 9'd0) begin
            wlen_nxt = wlen_r - 9'd1;
            if (wlen_r == 9'd1) on[2] = 1'b0;
          end
          if ((phase_r == 3'd1 || phase_r == 3'd3) && nr10[6:4] != 3'd0) begin
            if (swc_r >= nr10[6:4]) begin
              if (sum > {1'b0, slse_pkg::FREQ_MAX}) on[0] = 1'b0;
              swc_nxt        = 3'd0;
              wb_nxt.en[1]   = 1'b1;
              wb_nxt.addr[1] = slse_pkg::R_NR13;
              wb_nxt.data[1] = f[7:0];
              wb_nxt.en[2]   = 1'b1;
              wb_nxt.addr[2] = slse_pkg::R_NR14;
              wb_nxt.data[2] = {cap[0][7:3], f[10:8]};
            end else begin
              swc_nxt = swc_r + 3'd1;
            end
          end
          wb_nxt.en[0]   = 1'b1;
          wb_nxt.addr[0] = slse_pkg::R_NR52;
          wb_nxt.data[0] = {cap[4][7:4], on};
          phase_nxt      = phase_r + 3'd1;
        end
      end
      slse_pkg::FN_RELOAD: begin
        case (item.ch)
          slse_pkg::CH_SQ1:  len_nxt[0] = slse_pkg::short_len(cap[0]);
          slse_pkg::CH_SQ2:  len_nxt[1] = slse_pkg::short_len(cap[0]);
          slse_pkg::CH_WAVE: wlen_nxt   = slse_pkg::wave_len(cap[0]);
          default:           len_nxt[2] = slse_pkg::short_len(cap[0]);
        endcase
      end
      slse_pkg::FN_TRIG: begin
        on = cap[2][3:0];
        if (item.ch == slse_pkg::CH_WAVE) begin
          if (wlen_r == 9'd0) wlen_nxt = slse_pkg::wave_len(cap[0]);
          on[2] = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (slot == 2'(k)) begin
              if (len_r[k] == 7'd0) len_nxt[k] = slse_pkg::short_len(cap[0]);
              vol_nxt[k] = cap[1][7:4];
            end
          end
          if ((cap[1] & slse_pkg::ON_MASK) != 8'd0) on[item.ch] = 1'b1;
        end
        wb_nxt.en[0]   = 1'b1;
        wb_nxt.addr[0] = slse_pkg::R_NR52;
        wb_nxt.data[0] = {cap[2][7:4], on};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      wlen_r  <= '0;
      swc_r   <= '0;
      vol_r   <= '0;
      res_r   <= '0;
      phase_r <= '0;
      wb_r    <= '0;
      rd_r    <= '0;
    end else if (calc_en) begin
      len_r   <= len_nxt;
      wlen_r  <= wlen_nxt;
      swc_r   <= swc_nxt;
      vol_r   <= vol_nxt;
      res_r   <= res_nxt;
      phase_r <= phase_nxt;
      wb_r    <= wb_nxt;
      rd_r    <= rd_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sound_length_sweep_envelope_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sound_length_sweep_envelope_unit
// Control part of a four-channel sound unit: register bytes, length counters,
// frequency sweep of square channel 1 and volume envelopes.
//
// Input channel (in_valid/in_ready): one command per transfer - register
// write, register read, frame tick, length reload or trigger. Output channel
// (out_valid/out_ready): exactly one result per command, carrying the read
// byte (zero unless a read), the channel on bits, the three envelope volumes
// and the square 1 frequency, all as they stand after the command.
// Each command walks a sequencer: it fetches the register bytes it needs from
// the register store one per cycle (its read port is registered), works out
// the new state, then walks the write-back list. Commands are processed one
// at a time; the next command is taken as soon as the result has moved to
// the output register, even if that result is still waiting.
// Reset (rst_n low, synchronous) zeroes all registers, counters and phases.
// While the receiver stalls, a finished command holds in the sequencer and
// no further command is taken.
// ----------------------------------------------------------------------------
module sound_length_sweep_envelope_unit #(
  parameter int REGISTER_COUNT = 23
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_func,
  input  wire logic [4:0]  in_reg_index,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [1:0]  in_channel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_data,
  output logic [3:0]       out_channel_on,
  output logic [3:0]       out_square1_volume,
  output logic [3:0]       out_square2_volume,
  output logic [3:0]       out_noise_volume,
  output logic [10:0]      out_square1_freq
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                state_r, state_nxt;
  logic [2:0]                step_r, step_nxt;
  slse_pkg::item_t           item_r;
  slse_pkg::cap_t            cap_r;
  logic [3:0]                on_r;
  logic [10:0]               freq_r;
  logic                      out_valid_r;
  logic [7:0]                o_rd_r;
  logic [3:0]                o_on_r;
  logic [2:0][3:0]           o_vol_r;
  logic [10:0]               o_freq_r;

  logic                      in_xfer;
  logic                      load_out;
  logic [2:0]                rcnt;
  logic                      mem_we;
  logic [slse_pkg::AW-1:0]   mem_waddr;
  logic [7:0]                mem_wdata;
  logic [slse_pkg::AW-1:0]   mem_raddr;
  logic [7:0]                mem_rdata;
  logic                      calc_en;
  logic [1:0]                wi;
  slse_pkg::wb_t             wb;
  logic [7:0]                rd_data;
  logic [2:0][3:0]           vol;
  logic                      ph_env;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign rcnt      = slse_pkg::rd_count(item_r, ph_env);
  assign mem_raddr = slse_pkg::rd_addr(item_r, ph_env, step_r);
  assign calc_en   = (state_r == ST_CALC);
  assign wi        = step_r[1:0];
  assign mem_we    = (state_r == ST_WR) && wb.en[wi];
  assign mem_waddr = wb.addr[wi];
  assign mem_wdata = wb.data[wi];

  slse_regmem #(
    .DEPTH (REGISTER_COUNT)
  ) u_regmem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  slse_chan u_chan (
    .clk     (clk),
    .rst_n   (rst_n),
    .calc_en (calc_en),
    .item    (item_r),
    .cap     (cap_r),
    .freq    (freq_r),
    .wb      (wb),
    .rd_data (rd_data),
    .vol     (vol),
    .ph_env  (ph_env)
  );

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_RD;
          step_nxt  = 3'd0;
        end
      end
      ST_RD: begin
        if (step_r == rcnt) begin
          state_nxt = ST_CALC;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_CALC: begin
        state_nxt = ST_WR;
        step_nxt  = 3'd0;
      end
      ST_WR: begin
        if (step_r == 3'(slse_pkg::WB_N - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 3'd0;
      on_r        <= 4'd0;
      freq_r      <= 11'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (mem_we) begin
        case (mem_waddr)
          slse_pkg::R_NR52: on_r         <= mem_wdata[3:0];
          slse_pkg::R_NR13: freq_r[7:0]  <= mem_wdata;
          slse_pkg::R_NR14: freq_r[10:8] <= mem_wdata[2:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.func  <= in_func;
      item_r.idx   <= in_reg_index;
      item_r.wdata <= in_write_data;
      item_r.ch    <= in_channel;
    end
    if (state_r == ST_RD && step_r != 3'd0) begin
      cap_r[step_r - 3'd1] <= mem_rdata;
    end
    if (load_out) begin
      o_rd_r   <= rd_data;
      o_on_r   <= on_r;
      o_vol_r  <= vol;
      o_freq_r <= freq_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = o_rd_r;
  assign out_channel_on     = o_on_r;
  assign out_square1_volume = o_vol_r[0];
  assign out_square2_volume = o_vol_r[1];
  assign out_noise_volume   = o_vol_r[2];
  assign out_square1_freq   = o_freq_r;

endmodule
`default_nettype wire

// ===== rtl/core/slse_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slse_checker
// Port-level checks for the sound length, sweep and envelope unit.
// ----------------------------------------------------------------------------
module slse_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [2:0]  in_func,
  input wire logic [4:0]  in_reg_index,
  input wire logic [7:0]  in_write_data,
  input wire logic [1:0]  in_channel,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_read_data,
  input wire logic [3:0]  out_channel_on,
  input wire logic [3:0]  out_square1_volume,
  input wire logic [3:0]  out_square2_volume,
  input wire logic [3:0]  out_noise_volume,
  input wire logic [10:0] out_square1_freq
);

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("unit not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("command taken while previous one in flight");

  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too soon after transfer");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_func)
      && $stable(in_reg_index) && $stable(in_write_data) && $stable(in_channel))
    else $error("waiting command changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_channel_on) && $stable(out_square1_volume)
      && $stable(out_square2_volume) && $stable(out_noise_volume)
      && $stable(out_square1_freq))
    else $error("stalled result changed");

endmodule

bind sound_length_sweep_envelope_unit slse_checker u_slse_checker (.*);
`default_nettype wire

// ===== tb/sound_length_sweep_envelope_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sound_length_sweep_envelope_unit_test
// Self-checking bench for the sound length, sweep and envelope unit. A
// behavioral copy of the register bytes, length counters, sweep and envelope
// state predicts the status returned for every command transfer. Directed
// commands cover the corner cases first, then weighted random traffic runs
// with random idling on both sides, a long result stall, and a full-rate tail.
// ----------------------------------------------------------------------------
module sound_length_sweep_envelope_unit_test;

  localparam int REG_COUNT    = 23;
  localparam int STEP_WRAP    = 840;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int TIMEOUT_NS   = 10_000_000;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [3:0]  channel_on;
    logic [3:0]  sq1_vol;
    logic [3:0]  sq2_vol;
    logic [3:0]  noise_vol;
    logic [10:0] sq1_freq;
  } status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_func = slse_pkg::FN_WRITE;
  logic [4:0]  in_reg_index = '0;
  logic [7:0]  in_write_data = '0;
  logic [1:0]  in_channel = slse_pkg::CH_SQ1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic [3:0]  out_channel_on;
  logic [3:0]  out_square1_volume;
  logic [3:0]  out_square2_volume;
  logic [3:0]  out_noise_volume;
  logic [10:0] out_square1_freq;

  sound_length_sweep_envelope_unit #(.REGISTER_COUNT(REG_COUNT)) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_reg_index       (in_reg_index),
    .in_write_data      (in_write_data),
    .in_channel         (in_channel),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_channel_on     (out_channel_on),
    .out_square1_volume (out_square1_volume),
    .out_square2_volume (out_square2_volume),
    .out_noise_volume   (out_noise_volume),
    .out_square1_freq   (out_square1_freq)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Sound unit shadow state
  logic [7:0] snd_reg [REG_COUNT];
  logic [6:0] len_short [3];
  logic [8:0] len_wave;
  logic [2:0] sweep_cnt;
  logic [3:0] env_vol [3];
  logic [9:0] env_step;
  logic [2:0] frame_ph;

  status_t expected_status [$];

  int  sender_idle_pct = 0;
  logic receiver_idle_on = 1'b0;
  logic long_hold_req = 1'b0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_ticks = 0;
  int  n_triggers = 0;
  int  n_mismatch = 0;

  function automatic logic [10:0] sq1_freq_now();
    return {snd_reg[slse_pkg::R_NR14][2:0], snd_reg[slse_pkg::R_NR13]};
  endfunction

  function automatic void set_on_bit(input int b, input logic v);
    snd_reg[slse_pkg::R_NR52][b] = v;
  endfunction

  function automatic void reload_len(input logic [1:0] ch);
    case (ch)
      slse_pkg::CH_SQ1:  len_short[0] = 7'd64 - {1'b0, snd_reg[slse_pkg::R_NR11][5:0]};
      slse_pkg::CH_SQ2:  len_short[1] = 7'd64 - {1'b0, snd_reg[slse_pkg::R_NR21][5:0]};
      slse_pkg::CH_WAVE: len_wave = 9'd256 - {1'b0, snd_reg[slse_pkg::R_NR31]};
      default:           len_short[2] = 7'd64 - {1'b0, snd_reg[slse_pkg::R_NR41][5:0]};
    endcase
  endfunction

  function automatic void frame_step();
    int         k, f, d;
    logic [4:0] ctl;
    logic [7:0] r;
    if (frame_ph <= 3) begin
      for (k = 0; k < 3; k++) begin
        ctl = (k == 0) ? slse_pkg::R_NR14 : (k == 1) ? slse_pkg::R_NR24 : slse_pkg::R_NR44;
        if (snd_reg[ctl][slse_pkg::LEN_EN_BIT] && len_short[k] != 0) begin
          len_short[k] = len_short[k] - 7'd1;
          if (len_short[k] == 0) set_on_bit((k == 2) ? 3 : k, 1'b0);
        end
      end
      if (snd_reg[slse_pkg::R_NR34][slse_pkg::LEN_EN_BIT] && len_wave != 0) begin
        len_wave = len_wave - 9'd1;
        if (len_wave == 0) set_on_bit(2, 1'b0);
      end
    end
    if (frame_ph == 1 || frame_ph == 3) begin
      r = snd_reg[slse_pkg::R_NR10];
      if (r[6:4] != 0) begin
        if (sweep_cnt >= r[6:4]) begin
          f = int'(sq1_freq_now());
          d = f >> r[2:0];
          f = r[3] ? f - d : f + d;
          if (f > int'(slse_pkg::FREQ_MAX)) begin
            set_on_bit(0, 1'b0);
            f = int'(slse_pkg::FREQ_MAX);
          end
          sweep_cnt = '0;
          snd_reg[slse_pkg::R_NR13] = f[7:0];
          snd_reg[slse_pkg::R_NR14][2:0] = f[10:8];
        end else begin
          sweep_cnt = sweep_cnt + 3'd1;
        end
      end
    end
    if (frame_ph == slse_pkg::PH_ENV) begin
      for (k = 0; k < 3; k++) begin
        r = snd_reg[(k == 0) ? slse_pkg::R_NR12 : (k == 1) ? slse_pkg::R_NR22
                                                            : slse_pkg::R_NR42];
        if (r[2:0] != 0 && (env_step % 10'(r[2:0])) == 0) begin
          if (r[3]) begin
            if (env_vol[k] != 4'd15) env_vol[k] = env_vol[k] + 4'd1;
          end else begin
            if (env_vol[k] != 4'd0) env_vol[k] = env_vol[k] - 4'd1;
          end
        end
      end
      env_step = (env_step == 10'(STEP_WRAP - 1)) ? '0 : env_step + 10'd1;
    end
    frame_ph = (frame_ph >= slse_pkg::PH_ENV) ? '0 : frame_ph + 3'd1;
  endfunction

  function automatic status_t apply_command(input logic [2:0] func, input logic [4:0] idx,
                                            input logic [7:0] data, input logic [1:0] ch);
    status_t    s;
    int         slot;
    logic [7:0] r;
    s.read_data = 8'h00;
    case (func)
      slse_pkg::FN_WRITE:  if (idx < REG_COUNT) snd_reg[idx] = data;
      slse_pkg::FN_READ:   s.read_data = (idx < REG_COUNT) ? snd_reg[idx] : 8'h00;
      slse_pkg::FN_TICK:   frame_step();
      slse_pkg::FN_RELOAD: reload_len(ch);
      slse_pkg::FN_TRIG: begin
        if (ch == slse_pkg::CH_WAVE) begin
          if (len_wave == 0) reload_len(ch);
          set_on_bit(2, 1'b1);
        end else begin
          slot = (ch == slse_pkg::CH_NOISE) ? 2 : int'(ch);
          if (len_short[slot] == 0) reload_len(ch);
          r = snd_reg[(ch == slse_pkg::CH_SQ1) ? slse_pkg::R_NR12 :
                      (ch == slse_pkg::CH_SQ2) ? slse_pkg::R_NR22 : slse_pkg::R_NR42];
          env_vol[slot] = r[7:4];
          if ((r & slse_pkg::ON_MASK) != 0) set_on_bit(int'(ch), 1'b1);
        end
      end
      default: ;
    endcase
    s.channel_on = snd_reg[slse_pkg::R_NR52][3:0];
    s.sq1_vol    = env_vol[0];
    s.sq2_vol    = env_vol[1];
    s.noise_vol  = env_vol[2];
    s.sq1_freq   = sq1_freq_now();
    return s;
  endfunction

  task automatic send_command(input logic [2:0] func, input logic [4:0] idx,
                              input logic [7:0] data, input logic [1:0] ch);
    in_valid      <= 1'b1;
    in_func       <= func;
    in_reg_index  <= idx;
    in_write_data <= data;
    in_channel    <= ch;
    do @(posedge clk); while (!(in_valid && in_ready));
    expected_status.push_back(apply_command(func, idx, data, ch));
    n_sent++;
    if (func == slse_pkg::FN_TICK) n_ticks++;
    if (func == slse_pkg::FN_TRIG) n_triggers++;
    if (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_random_command();
    logic [2:0] func;
    logic [4:0] idx;
    logic [7:0] data;
    logic [1:0] ch;
    int         sel;
    func = 3'($urandom);
    idx  = 5'($urandom);
    data = 8'($urandom);
    ch   = 2'($urandom);
    sel  = $urandom_range(0, 99);
    if (sel < 30) begin
      func = slse_pkg::FN_WRITE;
      idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(23, 31))
                                        : 5'($urandom_range(0, REG_COUNT - 1));
      if ((idx == slse_pkg::R_NR11 || idx == slse_pkg::R_NR21 || idx == slse_pkg::R_NR41)
          && $urandom_range(0, 1))
        data[5:3] = 3'b111;
      if (idx == slse_pkg::R_NR31 && $urandom_range(0, 1)) data[7:4] = 4'hF;
    end else if (sel < 44) begin
      func = slse_pkg::FN_READ;
      if ($urandom_range(0, 9) != 0) idx = 5'($urandom_range(0, REG_COUNT - 1));
    end else if (sel < 76) begin
      func = slse_pkg::FN_TICK;
    end else if (sel < 82) begin
      func = slse_pkg::FN_RELOAD;
    end else if (sel < 95) begin
      func = slse_pkg::FN_TRIG;
    end else begin
      func = 3'($urandom_range(5, 7));
    end
    send_command(func, idx, data, ch);
  endtask

  // Result side: random stalls, plus one long hold on request
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
        long_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= rst_n;
      end
    end
  end

  always @(posedge clk) begin : result_check
    status_t want, got;
    got = '{out_read_data, out_channel_on, out_square1_volume, out_square2_volume,
            out_noise_volume, out_square1_freq};
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t unexpected result: rd=%h on=%h vol=%h/%h/%h freq=%h", $realtime,
                   got.read_data, got.channel_on, got.sq1_vol, got.sq2_vol, got.noise_vol,
                   got.sq1_freq);
      end else begin
        want = expected_status.pop_front();
        n_checked++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("%0t mismatch #%0d: exp rd=%h on=%h vol=%h/%h/%h freq=%h",
                     $realtime, n_checked, want.read_data, want.channel_on, want.sq1_vol,
                     want.sq2_vol, want.noise_vol, want.sq1_freq);
            $display("    got rd=%h on=%h vol=%h/%h/%h freq=%h",
                     got.read_data, got.channel_on, got.sq1_vol, got.sq2_vol,
                     got.noise_vol, got.sq1_freq);
          end
        end
      end
    end
  end

  task automatic test_register_access();
    send_command(slse_pkg::FN_READ, slse_pkg::R_NR10, 8'h00, slse_pkg::CH_SQ1);
    send_command(slse_pkg::FN_WRITE, slse_pkg::R_NR52, 8'hFF, slse_pkg::CH_SQ1);
    send_command(slse_pkg::FN_READ, slse_pkg::R_NR52, 8'h00, slse_pkg::CH_SQ1);
    send_command(slse_pkg::FN_WRITE, 5'd31, 8'hAA, slse_pkg::CH_NOISE);
    send_command(slse_pkg::FN_READ, 5'd31, 8'h00, slse_pkg::CH_SQ1);
    send_command(slse_pkg::FN_READ, 5'd23, 8'h00, slse_pkg::CH_SQ1);
  endtask

  // Length expiry, sweep overflow with clamp, envelope saturation
  task automatic test_length_sweep_envelope();
    send_command(slse_pkg::FN_WRITE, slse_pkg::R_NR11, 8'h3F, slse_pkg::CH_SQ1);
    send_command(slse_pkg::FN_WRITE, slse_pkg::R_NR12, 8'hF9, slse_pkg::CH_SQ1);
    send_command(slse_pkg::FN_WRITE, slse_pkg::R_NR13, 8'hFF, slse_pkg::CH_SQ1);
    send_command(slse_pkg::FN_WRITE, slse_pkg::R_NR14, 8'h47, slse_pkg::CH_SQ1);
    send_command(slse_pkg::FN_TRIG, 5'd0, 8'h00, slse_pkg::CH_SQ1);
    send_command(slse_pkg::FN_TICK, 5'd0, 8'h00, slse_pkg::CH_SQ1);
    send_command(slse_pkg::FN_WRITE, slse_pkg::R_NR10, 8'h11, slse_pkg::CH_SQ1);
    repeat (4) send_command(slse_pkg::FN_TICK, 5'd0, 8'h00, slse_pkg::CH_SQ1);
    send_command(slse_pkg::FN_WRITE, slse_pkg::R_NR10, 8'h7F, slse_pkg::CH_SQ1);
  endtask

  task automatic test_trigger_paths();
    send_command(slse_pkg::FN_WRITE, slse_pkg::R_NR31, 8'h00, slse_pkg::CH_WAVE);
    send_command(slse_pkg::FN_TRIG, 5'd0, 8'h00, slse_pkg::CH_WAVE);
    send_command(slse_pkg::FN_RELOAD, 5'd0, 8'h00, slse_pkg::CH_NOISE);
    send_command(slse_pkg::FN_WRITE, slse_pkg::R_NR22, 8'h07, slse_pkg::CH_SQ2);
    send_command(slse_pkg::FN_TRIG, 5'd0, 8'h00, slse_pkg::CH_SQ2);
    send_command(3'd5, 5'd0, 8'h00, slse_pkg::CH_SQ1);
    send_command(3'd7, 5'h1F, 8'hFF, slse_pkg::CH_NOISE);
  endtask

  task automatic test_random_traffic();
    int b;
    for (b = 0; b < 14; b++) begin
      case ($urandom_range(0, 2))
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 10;
        default: sender_idle_pct = 35;
      endcase
      receiver_idle_on = 1'($urandom);
      repeat (100) send_random_command();
    end
  endtask

  task automatic test_backpressure();
    sender_idle_pct  = 0;
    receiver_idle_on = 1'b0;
    long_hold_req    = 1'b1;
    repeat (150) send_random_command();
    while (long_hold_req) @(posedge clk);
  endtask

  task automatic test_full_rate();
    sender_idle_pct  = 0;
    receiver_idle_on = 1'b0;
    repeat (300) send_random_command();
  endtask

  initial begin
    int i;
    for (i = 0; i < REG_COUNT; i++) snd_reg[i] = 8'h00;
    for (i = 0; i < 3; i++) begin
      len_short[i] = '0;
      env_vol[i] = '0;
    end
    len_wave  = '0;
    sweep_cnt = '0;
    env_step  = '0;
    frame_ph  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_length_sweep_envelope();
    test_trigger_paths();
    test_random_traffic();
    test_backpressure();
    test_full_rate();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results for %0d commands: %0d frame ticks, %0d triggers.",
             n_checked, n_sent, n_ticks, n_triggers);
    $display("Random idling on both sides, one %0d-cycle result stall, full-rate tail.",
             LONG_HOLD);
    if (n_mismatch == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatching results", n_mismatch);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Timeout with %0d results outstanding", expected_status.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/slse_pkg.sv
rtl/core/slse_regmem.sv
rtl/core/slse_chan.sv
rtl/core/sound_length_sweep_envelope_unit.sv
rtl/core/slse_checker.sv
tb/sound_length_sweep_envelope_unit_test.sv
